// ===== src/rarsf_pkg.sv =====
// Package for the range-add / range-sum Fenwick block.
// Holds field widths, operation codes, the reset size and the tree word type.
// No dependencies.
`default_nettype none

package rarsf_pkg;

	localparam int unsigned DEF_SIZE = 65536;

	localparam int ACT_W   = 17;
	localparam int POS_W   = 17;
	localparam int DELTA_W = 32;
	localparam int SUM_W   = 64;

	localparam logic [ACT_W-1:0] ACT_RESET = 17'd65536;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUM = 1'b1;

	// One entry of each tree, read and written together at the same position.
	typedef struct packed {
		logic [SUM_W-1:0] scaled;
		logic [SUM_W-1:0] plain;
	} tree_word_t;

endpackage

`default_nettype wire

// ===== src/rarsf_tree_ram.sv =====
// Storage for both Fenwick trees: one read port with a registered output and
// one write port, plus the clearing sweep that zeroes every entry after reset.
// Depends on rarsf_pkg.
`default_nettype none

module rarsf_tree_ram #(
	parameter int unsigned SIZE = rarsf_pkg::DEF_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [$clog2(SIZE+1)-1:0]     raddr,
	output rarsf_pkg::tree_word_t              rdata,
	input  wire logic                          we,
	input  wire logic [$clog2(SIZE+1)-1:0]     waddr,
	input  wire rarsf_pkg::tree_word_t         wdata,
	output logic                               ready
);
	import rarsf_pkg::*;

	localparam int AW = $clog2(SIZE + 1);
	localparam logic [AW-1:0] LAST = AW'(SIZE);

	logic [SUM_W-1:0] scaled_mem [0:SIZE];
	logic [SUM_W-1:0] plain_mem  [0:SIZE];

	logic          clearing_q;
	logic [AW-1:0] clr_q;
	tree_word_t    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == LAST) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			scaled_mem[clr_q] <= '0;
			plain_mem[clr_q]  <= '0;
		end else if (we) begin
			scaled_mem[waddr] <= wdata.scaled;
			plain_mem[waddr]  <= wdata.plain;
		end
		rdata_q.scaled <= scaled_mem[raddr];
		rdata_q.plain  <= plain_mem[raddr];
	end

	assign rdata = rdata_q;
	assign ready = !clearing_q;

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !we)
		else $error("tree write during clearing sweep");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing sweep restarted without reset");

	a_clear_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(clearing_q && clr_q != LAST) |=> (clr_q == $past(clr_q) + 1'b1))
		else $error("clearing sweep skipped an entry");

endmodule

`default_nettype wire

// ===== src/range_add_range_sum_fenwick.sv =====
// Top level of the range-add / range-sum block built on two Fenwick trees.
// Sequencer for tree walks, multiply steps and result; uses rarsf_tree_ram.
// Depends on rarsf_pkg.
//
// Channel   Handshake          Payload
// input     start / busy       operation, left, right, delta
// result    done (strobe)      range_sum, range_error
// config    cfg_we             cfg_data (active_size)
//
// One item at a time; busy is high while an item is in work.
// In an update step the read of the next position overlaps the write of the
// current one; each walk starts with setup and issue states and has up to
// log2(SIZE)+1 steps. An add runs up to three walks.
// A sum runs two prefix walks, each followed by a two-part 64x17 multiply and
// an add, and ends in a subtraction. A bad range finishes at once.
// After reset the trees are cleared, all SIZE+1 entries, with busy high.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none

module range_add_range_sum_fenwick #(
	parameter int unsigned SIZE = rarsf_pkg::DEF_SIZE
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  operation,
	input  wire logic [rarsf_pkg::POS_W-1:0]           left,
	input  wire logic [rarsf_pkg::POS_W-1:0]           right,
	input  wire logic signed [rarsf_pkg::DELTA_W-1:0]  delta,
	input  wire logic                                  cfg_we,
	input  wire logic [rarsf_pkg::ACT_W-1:0]           cfg_data,
	output logic                                       done,
	output logic signed [rarsf_pkg::SUM_W-1:0]         range_sum,
	output logic                                       range_error
);
	import rarsf_pkg::*;

	localparam int AW   = $clog2(SIZE + 1);
	localparam int CW   = ((AW > ACT_W) ? AW : ACT_W) + 1;
	localparam int PRDW = DELTA_W + AW + 1;
	localparam int LOW  = 32 + AW;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_U_SETUP = 4'd1;
	localparam logic [3:0] ST_U_ISSUE = 4'd2;
	localparam logic [3:0] ST_U_RMW   = 4'd3;
	localparam logic [3:0] ST_Q_SETUP = 4'd4;
	localparam logic [3:0] ST_Q_ISSUE = 4'd5;
	localparam logic [3:0] ST_Q_ACC   = 4'd6;
	localparam logic [3:0] ST_Q_MLO   = 4'd7;
	localparam logic [3:0] ST_Q_MHI   = 4'd8;
	localparam logic [3:0] ST_Q_SUM   = 4'd9;
	localparam logic [3:0] ST_Q_OUT   = 4'd10;

	// Walk selector: from right+1, from left, and the plain walk from one.
	localparam logic [1:0] WALK_RIGHT = 2'd0;
	localparam logic [1:0] WALK_BELOW = 2'd1;
	localparam logic [1:0] WALK_FIRST = 2'd2;

	logic [3:0]                 state_q;
	logic [1:0]                 wsel_q;
	logic [ACT_W-1:0]           active_size_q;
	logic [AW-1:0]              n_q;
	logic [AW-1:0]              right_q;
	logic [AW-1:0]              below_q;
	logic signed [DELTA_W-1:0]  d_q;
	logic [AW:0]                pos_q;
	logic signed [PRDW-1:0]     prod_q;
	logic [SUM_W-1:0]           sv_q;
	logic [SUM_W-1:0]           pv_q;
	logic [AW-1:0]              xw_q;
	logic [SUM_W-1:0]           acc_s_q;
	logic [SUM_W-1:0]           acc_p_q;
	logic [LOW-1:0]             lo_q;
	logic [31:0]                hi_q;
	logic [SUM_W-1:0]           pr_q;
	logic                       done_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       err_q;

	logic                       ram_ready;
	tree_word_t                 rdata;
	tree_word_t                 wdata;
	logic [AW-1:0]              raddr;
	logic                       we;

	logic [CW-1:0]              act_c;
	logic [CW-1:0]              size_c;
	logic [CW-1:0]              n_c;
	logic                       in_err;
	logic [POS_W-1:0]           below_in;
	logic                       accept;
	logic [AW-1:0]              x_w;
	logic [AW:0]                start_w;
	logic                       walk_on;
	logic [AW:0]                up_next;
	logic [AW:0]                dn_next;
	logic signed [PRDW-1:0]     prod_w;
	logic [LOW-1:0]             lo_w;
	logic [31:0]                hi_w;
	logic [SUM_W-1:0]           d_ext;

	always_comb begin
		act_c    = CW'(active_size_q);
		size_c   = CW'(SIZE);
		n_c      = (act_c > size_c) ? size_c : act_c;
		in_err   = (left > right) || (CW'(right) > n_c);
		below_in = (left != '0) ? (left - 1'b1) : '0;
		accept   = start && !busy;
	end

	always_comb begin
		x_w     = (wsel_q == WALK_RIGHT) ? right_q : below_q;
		start_w = (wsel_q == WALK_FIRST) ? (AW+1)'(1) : ({1'b0, x_w} + 1'b1);
		if (wsel_q == WALK_FIRST) begin
			// The plain walks from position one cancel unless the range starts at one.
			walk_on = (below_q == '0) && (right_q != '0);
		end else begin
			walk_on = (x_w != '0);
		end
		walk_on = walk_on && (start_w <= {1'b0, n_q});
		up_next = pos_q + (pos_q & (~pos_q + 1'b1));
		dn_next = pos_q & (pos_q - 1'b1);
		prod_w  = d_q * $signed({1'b0, x_w});
		lo_w    = acc_p_q[31:0] * xw_q;
		hi_w    = acc_p_q[63:32] * 32'(xw_q);
		d_ext   = {{(SUM_W-DELTA_W){d_q[DELTA_W-1]}}, d_q};
	end

	always_comb begin
		raddr = pos_q[AW-1:0];
		if (state_q == ST_U_RMW && up_next <= {1'b0, n_q}) begin
			raddr = up_next[AW-1:0];
		end else if (state_q == ST_Q_ACC && dn_next != '0) begin
			raddr = dn_next[AW-1:0];
		end
		we           = (state_q == ST_U_RMW);
		wdata.scaled = rdata.scaled + sv_q;
		wdata.plain  = rdata.plain + pv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACT_RESET;
		end else if (cfg_we) begin
			active_size_q <= cfg_data;
		end
	end

	// The strobe follows a bad-range sum at once, or the last step of a good sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_Q_OUT)
				|| (state_q == ST_IDLE && accept && operation == OP_SUM && in_err);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wsel_q  <= WALK_RIGHT;
			n_q     <= '0;
			right_q <= '0;
			below_q <= '0;
			d_q     <= '0;
			pos_q   <= '0;
			prod_q  <= '0;
			sv_q    <= '0;
			pv_q    <= '0;
			xw_q    <= '0;
			acc_s_q <= '0;
			acc_p_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			pr_q    <= '0;
			sum_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= n_c[AW-1:0];
						right_q <= AW'(right);
						below_q <= AW'(below_in);
						d_q     <= delta;
						wsel_q  <= WALK_RIGHT;
						if (operation == OP_SUM) begin
							if (in_err) begin
								sum_q  <= '0;
								err_q  <= 1'b1;
							end else begin
								state_q <= ST_Q_SETUP;
							end
						end else if (!in_err) begin
							state_q <= ST_U_SETUP;
						end
					end
				end
				ST_U_SETUP: begin
					prod_q <= prod_w;
					if (walk_on) begin
						pos_q   <= start_w;
						state_q <= ST_U_ISSUE;
					end else if (wsel_q == WALK_FIRST) begin
						state_q <= ST_IDLE;
					end else begin
						wsel_q <= wsel_q + 1'b1;
					end
				end
				ST_U_ISSUE: begin
					case (wsel_q)
						WALK_RIGHT: begin
							sv_q <= SUM_W'(prod_q);
							pv_q <= '0 - d_ext;
						end
						WALK_BELOW: begin
							sv_q <= '0 - SUM_W'(prod_q);
							pv_q <= d_ext;
						end
						default: begin
							sv_q <= '0;
							pv_q <= d_ext;
						end
					endcase
					state_q <= ST_U_RMW;
				end
				ST_U_RMW: begin
					if (up_next <= {1'b0, n_q}) begin
						pos_q <= up_next;
					end else if (wsel_q == WALK_FIRST) begin
						state_q <= ST_IDLE;
					end else begin
						wsel_q  <= wsel_q + 1'b1;
						state_q <= ST_U_SETUP;
					end
				end
				ST_Q_SETUP: begin
					xw_q    <= x_w;
					acc_s_q <= '0;
					acc_p_q <= '0;
					if (x_w != '0) begin
						pos_q   <= {1'b0, x_w};
						state_q <= ST_Q_ISSUE;
					end else begin
						state_q <= ST_Q_MLO;
					end
				end
				ST_Q_ISSUE: begin
					state_q <= ST_Q_ACC;
				end
				ST_Q_ACC: begin
					acc_s_q <= acc_s_q + rdata.scaled;
					acc_p_q <= acc_p_q + rdata.plain;
					if (dn_next != '0) begin
						pos_q <= dn_next;
					end else begin
						state_q <= ST_Q_MLO;
					end
				end
				ST_Q_MLO: begin
					lo_q    <= lo_w;
					state_q <= ST_Q_MHI;
				end
				ST_Q_MHI: begin
					acc_s_q <= acc_s_q + SUM_W'(lo_q);
					hi_q    <= hi_w;
					state_q <= ST_Q_SUM;
				end
				ST_Q_SUM: begin
					if (wsel_q == WALK_RIGHT) begin
						pr_q    <= acc_s_q + {hi_q, 32'd0};
						wsel_q  <= WALK_BELOW;
						state_q <= ST_Q_SETUP;
					end else begin
						acc_s_q <= acc_s_q + {hi_q, 32'd0};
						state_q <= ST_Q_OUT;
					end
				end
				ST_Q_OUT: begin
					sum_q   <= pr_q - acc_s_q;
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rarsf_tree_ram #(
		.SIZE(SIZE)
	) u_trees (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (rdata),
		.we     (we),
		.waddr  (pos_q[AW-1:0]),
		.wdata  (wdata),
		.ready  (ram_ready)
	);

	assign busy        = (state_q != ST_IDLE) || !ram_ready;
	assign done        = done_q;
	assign range_sum   = sum_q;
	assign range_error = err_q;

	a_walk_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_U_RMW) |-> (pos_q != '0 && pos_q <= {1'b0, n_q}))
		else $error("update walk left the active range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_U_RMW && up_next <= {1'b0, n_q}) |-> (raddr != pos_q[AW-1:0]))
		else $error("read of the entry being written back");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (range_sum == '0))
		else $error("bad range returned a nonzero sum");

	a_idle_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!ram_ready |-> (state_q == ST_IDLE && !done))
		else $error("work started during tree clearing");

endmodule

`default_nettype wire

// ===== tb/range_add_range_sum_fenwick_tb.sv =====
// Self-checking testbench for range_add_range_sum_fenwick: range adds and range sums
// checked against a Fenwick-tree predictor kept inside the bench.
// Depends on rarsf_pkg and the block's RTL.
module range_add_range_sum_fenwick_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rarsf_pkg::*;

	localparam int MAX_POS      = DEF_SIZE;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int POS_MAX_CODE = (1 << POS_W) - 1;

	typedef enum bit {OFFS_TREE, RATE_TREE} tree_sel_t;

	typedef struct {
		logic [SUM_W-1:0] total;
		logic             err;
	} sum_expect_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       operation;
	logic [POS_W-1:0]           left;
	logic [POS_W-1:0]           right;
	logic signed [DELTA_W-1:0]  delta;
	logic                       cfg_we;
	logic [ACT_W-1:0]           cfg_data;
	logic                       done;
	logic signed [SUM_W-1:0]    range_sum;
	logic                       range_error;

	// Predictor state: offsets (delta times position) and rates (plain deltas).
	bit [SUM_W-1:0] offs_tree [0:MAX_POS];
	bit [SUM_W-1:0] rate_tree [0:MAX_POS];
	int             act_size = int'(ACT_RESET);

	sum_expect_t pending_sums[$];

	int  fail_count   = 0;
	int  cycle_count  = 0;
	int  adds_sent    = 0;
	int  sums_sent    = 0;
	int  bad_ranges   = 0;
	int  sums_checked = 0;
	int  cfg_writes   = 0;
	bit  gaps_on      = 1'b1;

	range_add_range_sum_fenwick dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.left        (left),
		.right       (right),
		.delta       (delta),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.range_sum   (range_sum),
		.range_error (range_error)
	);

	always #5 clk = ~clk;

	function automatic void report_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic int walk_limit();
		return (act_size > MAX_POS) ? MAX_POS : act_size;
	endfunction

	function automatic void tree_bump(tree_sel_t which, int pos, logic [SUM_W-1:0] v, int n);
		while (pos >= 1 && pos <= n) begin
			if (which == RATE_TREE)
				rate_tree[pos] += v;
			else
				offs_tree[pos] += v;
			pos += pos & -pos;
		end
	endfunction

	function automatic logic [SUM_W-1:0] tree_prefix(tree_sel_t which, int pos);
		logic [SUM_W-1:0] acc;
		acc = '0;
		while (pos != 0) begin
			acc += (which == RATE_TREE) ? rate_tree[pos] : offs_tree[pos];
			pos -= pos & -pos;
		end
		return acc;
	endfunction

	// Adds d to positions 1..i as one offset and two rate updates.
	function automatic void add_leading(int i, logic [SUM_W-1:0] d, int n);
		if (i == 0)
			return;
		tree_bump(OFFS_TREE, i + 1, d * SUM_W'(i), n);
		tree_bump(RATE_TREE, 1, d, n);
		tree_bump(RATE_TREE, i + 1, -d, n);
	endfunction

	function automatic logic [SUM_W-1:0] prefix_total(int x);
		if (x == 0)
			return '0;
		return tree_prefix(OFFS_TREE, x) + tree_prefix(RATE_TREE, x) * SUM_W'(x);
	endfunction

	// Updates the trees for an add, or queues the expected total for a sum.
	function automatic void fenwick_apply(logic op, int l, int r, logic [DELTA_W-1:0] d);
		int               n;
		int               below;
		logic             err;
		logic [SUM_W-1:0] d64;
		sum_expect_t      want;
		n     = walk_limit();
		err   = (l > r) || (r > n);
		below = (l > 0) ? l - 1 : 0;
		d64   = {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
		if (err)
			bad_ranges++;
		if (op == OP_ADD) begin
			adds_sent++;
			if (!err) begin
				add_leading(r, d64, n);
				add_leading(below, -d64, n);
			end
		end else begin
			sums_sent++;
			want.err   = err;
			want.total = err ? '0 : prefix_total(r) - prefix_total(below);
			pending_sums.push_back(want);
		end
	endfunction

	always @(posedge clk) begin : check_results
		sum_expect_t want;
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				report_fail($sformatf("result with none expected: sum=%h err=%b",
					range_sum, range_error));
			end else begin
				want = pending_sums.pop_front();
				sums_checked++;
				if (range_sum !== want.total)
					report_fail($sformatf("range_sum expected %h got %h",
						want.total, range_sum));
				if (range_error !== want.err)
					report_fail($sformatf("range_error expected %b got %b",
						want.err, range_error));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d sums outstanding",
				cycle_count, pending_sums.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Drives one item and holds it until the transfer happens.
	task automatic send_item(logic op, logic [POS_W-1:0] l, logic [POS_W-1:0] r,
			logic [DELTA_W-1:0] d);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 99) < 36)
			gap = $urandom_range(1, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		left      <= l;
		right     <= r;
		delta     <= d;
		do @(posedge clk); while (busy);
		fenwick_apply(op, int'(l), int'(r), d);
	endtask

	// Holds the sender until all sums are back and any trailing add has finished.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_active_size(int v);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= ACT_W'(v);
		@(posedge clk);
		cfg_we   <= 1'b0;
		act_size = v & POS_MAX_CODE;
		cfg_writes++;
	endtask

	// Mostly well-formed ranges inside the active size, the rest anywhere in the field.
	task automatic send_random(int n);
		logic               op;
		logic [POS_W-1:0]   l;
		logic [POS_W-1:0]   r;
		logic [DELTA_W-1:0] d;
		int                 roll;
		op   = 1'($urandom_range(0, 1));
		d    = $urandom;
		if ($urandom_range(0, 3) == 0)
			d = $urandom_range(0, 15) - 8;
		roll = $urandom_range(0, 99);
		if (n >= 1 && roll < 85) begin
			l = POS_W'($urandom_range(1, n));
			if ($urandom_range(0, 2) == 0)
				r = POS_W'(l + $urandom_range(0, (n - l < 8) ? n - l : 8));
			else
				r = POS_W'($urandom_range(l, n));
		end else if (roll < 90) begin
			l = '0;
			r = POS_W'($urandom_range(0, n));
		end else begin
			l = POS_W'($urandom_range(0, POS_MAX_CODE));
			r = POS_W'($urandom_range(0, POS_MAX_CODE));
		end
		send_item(op, l, r, d);
	endtask

	task automatic test_directed_ops();
		send_item(OP_ADD, 1, MAX_POS, 32'h7fffffff);
		send_item(OP_SUM, 1, MAX_POS, 32'h0);
		send_item(OP_ADD, MAX_POS, MAX_POS, 32'h80000000);
		send_item(OP_SUM, MAX_POS, MAX_POS, 32'h0);
		send_item(OP_SUM, 1, 1, 32'h0);
		// A left of zero behaves as one; zero to zero is an empty range.
		send_item(OP_ADD, 0, 3, 32'hffffffff);
		send_item(OP_SUM, 0, 2, 32'h0);
		send_item(OP_ADD, 0, 0, 32'h12345678);
		send_item(OP_SUM, 0, 0, 32'h0);
		send_item(OP_ADD, 5, 4, 32'h1);
		send_item(OP_SUM, 5, 4, 32'h0);
		send_item(OP_SUM, 1, MAX_POS + 1, 32'h0);
		send_item(OP_ADD, POS_MAX_CODE, POS_MAX_CODE, 32'hffffffff);
		send_item(OP_SUM, POS_MAX_CODE, POS_MAX_CODE, 32'h0);
		send_item(OP_SUM, 2, MAX_POS - 1, 32'h0);
	endtask

	task automatic test_size_extremes();
		// With no positions in use every nonempty range is out of bounds.
		set_active_size(0);
		send_item(OP_SUM, 1, 1, 32'h0);
		send_item(OP_SUM, 0, 0, 32'h0);
		send_item(OP_ADD, 1, 1, 32'h5);
		set_active_size(1);
		send_item(OP_ADD, 1, 1, 32'h7fffffff);
		send_item(OP_SUM, 1, 1, 32'h0);
		send_item(OP_SUM, 1, 2, 32'h0);
		send_item(OP_SUM, 0, 1, 32'h0);
		// An oversized register acts as the full tree size.
		set_active_size(POS_MAX_CODE);
		send_item(OP_SUM, 1, MAX_POS, 32'h0);
		send_item(OP_SUM, 1, MAX_POS + 1, 32'h0);
		send_item(OP_ADD, 2, MAX_POS, 32'h80000001);
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		set_active_size(64);
		repeat (60) send_random(64);
		wait_drained();
		repeat (60) send_random(64);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int sizes [5];
		sizes = '{16, 2, 1000, MAX_POS, POS_MAX_CODE};
		foreach (sizes[i]) begin
			set_active_size(sizes[i]);
			repeat (55) send_random(walk_limit());
		end
		set_active_size($urandom_range(3, MAX_POS));
		repeat (55) send_random(walk_limit());
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_ADD;
		left      <= '0;
		right     <= '0;
		delta     <= '0;
		cfg_we    <= 1'b0;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_size_extremes();
		test_back_to_back();
		test_random_traffic();
		wait_drained();

		$display("Covered %0d adds and %0d sums (%0d with bad ranges), %0d sums checked",
			adds_sent, sums_sent, bad_ranges, sums_checked);
		$display("over %0d active-size settings including zero, one and oversized.",
			cfg_writes);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
